// ----- rtl/ssd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the descending selection sort core.
// No dependencies.
package ssd_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int SCORE_W   = 32;
    localparam int ID_W      = 8;

    // One stored record: signed Q24.8 score plus its identifier
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [ID_W-1:0]           id;
    } t_rec;

endpackage

// ----- rtl/selection_sort_descending_core.sv -----
`timescale 1ns / 1ps
// Descending selection sort core. Depends on ssd_pkg and ssd_store.
// Loading: one record request per cycle while busy is low.
// After the record marked last (n records stored), pass i reads entries i to n-1, lets
// the last read land, then writes back in S_SWAP; its result strobes in the cycle after
// S_SWAP. The receiver cannot stall. Synchronous active-low reset zeroes the fill count.
module selection_sort_descending_core #(
    parameter int DEPTH = ssd_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [ssd_pkg::SCORE_W-1:0] i_score,
    input  logic [ssd_pkg::ID_W-1:0]           i_record_id,
    input  logic                               i_last,
    output logic                               o_res_strobe,
    output logic signed [ssd_pkg::SCORE_W-1:0] o_score_res,
    output logic [ssd_pkg::ID_W-1:0]           o_record_id_res,
    output logic                               o_last_out,
    output logic                               o_dropped
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_LOAD = 3'b001,
        S_SCAN = 3'b010,
        S_SWAP = 3'b100
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_fill;
    logic          r_ovf;
    logic [IW-1:0] r_pass;
    logic [IW-1:0] r_addr;
    logic          r_issue_done;
    logic          r_rvld;
    logic [IW-1:0] r_ridx;
    logic [IW-1:0] r_best_idx;
    ssd_pkg::t_rec r_best;
    ssd_pkg::t_rec r_held;

    logic                               r_out_vld;
    logic signed [ssd_pkg::SCORE_W-1:0] r_out_score;
    logic [ssd_pkg::ID_W-1:0]           r_out_id;
    logic                               r_out_last;
    logic                               r_out_drop;

    logic          w_accept;
    logic          w_has_room;
    logic [IW-1:0] w_last_idx;
    logic          w_rd_en;
    logic          n_wr_en;
    logic [IW-1:0] n_wr_addr;
    ssd_pkg::t_rec n_wr_data;
    ssd_pkg::t_rec w_rd_data;
    ssd_pkg::t_rec w_in_rec;

    assign busy       = (r_state != S_LOAD);
    assign w_accept   = start && !busy;
    assign w_has_room = (r_fill < CW'(DEPTH));
    assign w_last_idx = IW'(r_fill - CW'(1));
    assign w_rd_en    = (r_state == S_SCAN) && !r_issue_done;

    assign w_in_rec.score = i_score;
    assign w_in_rec.id    = i_record_id;

    // store write mux: load request, or swap the old head entry into the winner's slot
    always_comb begin
        n_wr_en   = 1'b0;
        n_wr_addr = r_best_idx;
        n_wr_data = r_held;
        if (w_accept && w_has_room) begin
            n_wr_en   = 1'b1;
            n_wr_addr = r_fill[IW-1:0];
            n_wr_data = w_in_rec;
        end else if (r_state == S_SWAP) begin
            n_wr_en = 1'b1;
        end
    end

    ssd_store #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (n_wr_en),
        .i_wr_addr (n_wr_addr),
        .i_wr_data (n_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (w_rd_data)
    );

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_fill       <= '0;
            r_ovf        <= 1'b0;
            r_pass       <= '0;
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_rvld       <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_out_vld <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    r_rvld <= 1'b0;
                    if (w_accept) begin
                        if (w_has_room) begin
                            r_fill <= r_fill + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last) begin
                            r_state      <= S_SCAN;
                            r_pass       <= '0;
                            r_addr       <= '0;
                            r_issue_done <= 1'b0;
                        end
                    end
                end
                S_SCAN: begin
                    // issue reads from the pass head to the last stored entry
                    r_rvld <= !r_issue_done;
                    if (!r_issue_done) begin
                        if (r_addr == w_last_idx) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_addr <= r_addr + IW'(1);
                        end
                    end
                    // last compare lands this cycle
                    if (r_rvld && (r_ridx == w_last_idx)) begin
                        r_state <= S_SWAP;
                    end
                end
                S_SWAP: begin
                    r_rvld    <= 1'b0;
                    r_out_vld <= 1'b1;
                    if (r_pass == w_last_idx) begin
                        r_state <= S_LOAD;
                        r_fill  <= '0;
                        r_ovf   <= 1'b0;
                    end else begin
                        r_state      <= S_SCAN;
                        r_pass       <= r_pass + IW'(1);
                        r_addr       <= r_pass + IW'(1);
                        r_issue_done <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    // read index is a registered copy of the issued address, aligned with the read data
    always_ff @(posedge i_clk) begin
        r_ridx <= r_addr;
    end

    // running maximum: first strictly largest wins; head entry is kept for the swap
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN && r_rvld) begin
            if (r_ridx == r_pass) begin
                r_best     <= w_rd_data;
                r_held     <= w_rd_data;
                r_best_idx <= r_ridx;
            end else if (w_rd_data.score > r_best.score) begin
                r_best     <= w_rd_data;
                r_best_idx <= r_ridx;
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_SWAP) begin
            r_out_score <= r_best.score;
            r_out_id    <= r_best.id;
            r_out_last  <= (r_pass == w_last_idx);
            r_out_drop  <= r_ovf;
        end
    end

    assign o_res_strobe    = r_out_vld;
    assign o_score_res     = r_out_score;
    assign o_record_id_res = r_out_id;
    assign o_last_out      = r_out_last;
    assign o_dropped       = r_out_drop;

endmodule

// ----- rtl/ssd_store.sv -----
`timescale 1ns / 1ps
// Record store: one write port, one read port with registered read data.
// Depends on ssd_pkg (t_rec).
module ssd_store #(
    parameter int DEPTH = ssd_pkg::DEPTH_DEF,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [IW-1:0] i_wr_addr,
    input  ssd_pkg::t_rec i_wr_data,
    input  logic          i_rd_en,
    input  logic [IW-1:0] i_rd_addr,
    output ssd_pkg::t_rec o_rd_data
);

    ssd_pkg::t_rec r_mem [DEPTH];
    ssd_pkg::t_rec r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered read data, enabled by i_rd_en
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
